FILE: rtl/sha1md_pkg.sv
// Shared constants and helpers for the SHA-1 message digest block.
// Holds the initial hash values, round constants and the round mixing function.
// No dependencies.
`default_nettype none

package sha1md_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned NumHash  = 5;
    localparam int unsigned NumRound = 80;
    localparam int unsigned LenW     = 64;

    localparam logic [NumHash-1:0][WordW-1:0] SHA_IV = {
        32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE, 32'hEFCD_AB89, 32'h6745_2301
    };

    localparam logic [3:0][WordW-1:0] ROUND_K = {
        32'hCA62_C1D6, 32'h8F1B_BCDC, 32'h6ED9_EBA1, 32'h5A82_7999
    };

    // Round groups of twenty rounds each.
    typedef enum logic [1:0] {
        GRP_CHOOSE   = 2'd0,
        GRP_PARITY1  = 2'd1,
        GRP_MAJORITY = 2'd2,
        GRP_PARITY2  = 2'd3
    } round_grp_t;

    localparam logic [WordW-1:0] PAD_MARKER_WORD = 32'h8000_0000;

    function automatic logic [WordW-1:0] mix_fn(
        input round_grp_t       grp,
        input logic [WordW-1:0] b,
        input logic [WordW-1:0] c,
        input logic [WordW-1:0] d
    );
        logic [WordW-1:0] res;
        unique case (grp)
            GRP_CHOOSE:   res = (b & c) | (~b & d);
            GRP_MAJORITY: res = (b & c) | (b & d) | (c & d);
            GRP_PARITY1,
            GRP_PARITY2:  res = b ^ c ^ d;
            default:      res = b ^ c ^ d;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sha1_message_digest.sv
// SHA-1 message digest engine: word intake, padding, iterative compression, digest output.
// Depends on sha1md_pkg for constants and the round mixing function.
//
// Usage: message words arrive on the data channel (data_valid / data_stall) as
// big-endian 32-bit words with valid_bytes; end_of_message marks the final item,
// which may be partial or empty. Digest words leave on the digest channel
// (digest_valid / digest_stall), H0 first, with last_word set on H4.
// A non-final item that completes a 512-bit block starts the compression:
// one round per cycle on a single shared round adder for 80 rounds, then the
// working words are folded into the chaining value. A final item starts
// padding: the padding words are pushed one at a time, each block filled
// during padding (one or two) is compressed the same way, and then the five
// digest words are handed out.
// The engine takes no new message word while it compresses a block.
// data_stall is high whenever the engine is busy with padding, rounds, fold or output.
// A stall on the digest channel holds the current digest word and pauses output;
// the last digest word may wait in its output register while a new message starts.
// Reset loads the initial hash values and clears the length, word count and
// output valid; the block is then idle and ready to take an item once reset is released.
`default_nettype none

module sha1_message_digest (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        data_valid,
    output logic             data_stall,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  valid_bytes,
    input  wire logic        end_of_message,
    output logic             digest_valid,
    input  wire logic        digest_stall,
    output logic [31:0]      digest_word,
    output logic             last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_DATA,
        PH_MARK,
        PH_ZERO,
        PH_LENLO,
        PH_DONE
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  words_reg, words_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  emit_idx_reg, emit_idx_next;
    logic [63:0] len_reg, len_next;
    logic [4:0][31:0] chain_reg, chain_next;
    logic        digest_valid_reg, digest_valid_next;
    logic [31:0] digest_word_reg, digest_word_next;
    logic        last_word_reg, last_word_next;

    // Payload registers, no reset.
    logic [15:0][31:0] win_reg, win_next;
    logic [4:0][31:0]  work_reg, work_next;
    logic [31:0] tail_data_reg, tail_data_next;
    logic [2:0]  tail_nb_reg, tail_nb_next;

    logic [2:0]  nb_clip;
    logic        push_en;
    logic [31:0] push_word;
    logic [31:0] tail_word;
    logic [31:0] sched_word;
    logic [31:0] round_w;
    logic [31:0] round_sum;
    sha1md_pkg::round_grp_t grp;

    assign nb_clip = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

    // Final partial word: keep the used bytes and put the marker byte after them.
    always_comb
    begin
        unique case (tail_nb_reg[1:0])
            2'd0: tail_word = {8'h80, 24'h0};
            2'd1: tail_word = {tail_data_reg[31:24], 8'h80, 16'h0};
            2'd2: tail_word = {tail_data_reg[31:16], 8'h80, 8'h0};
            2'd3: tail_word = {tail_data_reg[31:8], 8'h80};
            default: tail_word = {8'h80, 24'h0};
        endcase
    end

    always_comb
    begin
        if (round_reg < 7'd20)
            grp = sha1md_pkg::GRP_CHOOSE;
        else if (round_reg < 7'd40)
            grp = sha1md_pkg::GRP_PARITY1;
        else if (round_reg < 7'd60)
            grp = sha1md_pkg::GRP_MAJORITY;
        else
            grp = sha1md_pkg::GRP_PARITY2;
    end

    // The window is a shift line: tap 0 is the oldest of the last sixteen words.
    assign sched_word = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign round_w    = (round_reg < 7'd16) ? win_reg[0] : {sched_word[30:0], sched_word[31]};
    assign round_sum  = {work_reg[0][26:0], work_reg[0][31:27]}
                      + sha1md_pkg::mix_fn(grp, work_reg[1], work_reg[2], work_reg[3])
                      + work_reg[4] + round_w + sha1md_pkg::ROUND_K[grp];

    assign data_stall   = (state_reg != ST_IDLE);
    assign digest_valid = digest_valid_reg;
    assign digest_word  = digest_word_reg;
    assign last_word    = last_word_reg;

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        words_next        = words_reg;
        round_next        = round_reg;
        emit_idx_next     = emit_idx_reg;
        len_next          = len_reg;
        chain_next        = chain_reg;
        digest_valid_next = digest_valid_reg;
        digest_word_next  = digest_word_reg;
        last_word_next    = last_word_reg;
        win_next          = win_reg;
        work_next         = work_reg;
        tail_data_next    = tail_data_reg;
        tail_nb_next      = tail_nb_reg;
        push_en           = 1'b0;
        push_word         = '0;

        if (digest_valid_reg && !digest_stall)
            digest_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (data_valid)
                begin
                    if (!end_of_message)
                    begin
                        if (valid_bytes != 3'd0)
                        begin
                            len_next  = len_reg + 64'd32;
                            push_en   = 1'b1;
                            push_word = data_word;
                        end
                    end
                    else
                    begin
                        len_next       = len_reg + {58'd0, nb_clip, 3'b000};
                        tail_data_next = data_word;
                        tail_nb_next   = nb_clip;
                        phase_next     = PH_DATA;
                        state_next     = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                push_en = 1'b1;
                unique case (phase_reg)
                    PH_DATA:
                    begin
                        if (tail_nb_reg == 3'd4)
                        begin
                            push_word  = tail_data_reg;
                            phase_next = PH_MARK;
                        end
                        else
                        begin
                            push_word  = tail_word;
                            phase_next = PH_ZERO;
                        end
                    end
                    PH_MARK:
                    begin
                        push_word  = sha1md_pkg::PAD_MARKER_WORD;
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO:
                    begin
                        if (words_reg == 4'd14)
                        begin
                            push_word  = len_reg[63:32];
                            phase_next = PH_LENLO;
                        end
                        else
                        begin
                            push_word = '0;
                        end
                    end
                    PH_LENLO:
                    begin
                        push_word  = len_reg[31:0];
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        push_en    = 1'b0;
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_ROUND:
            begin
                win_next     = {round_w, win_reg[15:1]};
                work_next[0] = round_sum;
                work_next[1] = work_reg[0];
                work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
                work_next[3] = work_reg[2];
                work_next[4] = work_reg[3];
                round_next   = round_reg + 7'd1;
                if (round_reg == 7'(sha1md_pkg::NumRound - 1))
                    state_next = ST_FOLD;
            end

            ST_FOLD:
            begin
                for (int i = 0; i < 5; i++)
                    chain_next[i] = chain_reg[i] + work_reg[i];
                if (phase_reg == PH_DONE)
                begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT;
                end
                else if (phase_reg == PH_NONE)
                    state_next = ST_IDLE;
                else
                    state_next = ST_PAD;
            end

            ST_EMIT:
            begin
                if (!digest_valid_reg || !digest_stall)
                begin
                    digest_valid_next = 1'b1;
                    digest_word_next  = chain_reg[emit_idx_reg];
                    last_word_next    = (emit_idx_reg == 3'd4);
                    emit_idx_next     = emit_idx_reg + 3'd1;
                    if (emit_idx_reg == 3'd4)
                    begin
                        chain_next = sha1md_pkg::SHA_IV;
                        words_next = '0;
                        len_next   = '0;
                        phase_next = PH_NONE;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Word intake; the sixteenth word of a block starts the rounds.
        if (push_en)
        begin
            win_next   = {push_word, win_reg[15:1]};
            words_next = words_reg + 4'd1;
            if (words_reg == 4'd15)
            begin
                work_next  = chain_reg;
                round_next = '0;
                state_next = ST_ROUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_NONE;
            words_reg        <= '0;
            round_reg        <= '0;
            emit_idx_reg     <= '0;
            len_reg          <= '0;
            chain_reg        <= sha1md_pkg::SHA_IV;
            digest_valid_reg <= 1'b0;
            digest_word_reg  <= '0;
            last_word_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            words_reg        <= words_next;
            round_reg        <= round_next;
            emit_idx_reg     <= emit_idx_next;
            len_reg          <= len_next;
            chain_reg        <= chain_next;
            digest_valid_reg <= digest_valid_next;
            digest_word_reg  <= digest_word_next;
            last_word_reg    <= last_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        work_reg      <= work_next;
        tail_data_reg <= tail_data_next;
        tail_nb_reg   <= tail_nb_next;
    end

    // A block always starts its rounds with an empty word count.
    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 7'd0) |-> (words_reg == 4'd0))
        else $error("rounds started with a partly filled block");

    // Padding only runs while a message end is being processed.
    a_pad_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD) |-> (phase_reg != PH_NONE && phase_reg != PH_DONE))
        else $error("padding state without an active padding phase");

    // Once the last digest word is taken, no further last word can follow at once.
    a_last_once: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && last_word) |=> !(digest_valid && last_word))
        else $error("last digest word repeated");

    // The round counter never runs past the final round.
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg < 7'(sha1md_pkg::NumRound)))
        else $error("round counter out of range");

endmodule

`default_nettype wire
